>>> rtl/core/qte_pkg.sv
// Shared widths, constants and payload types for the quaternion to Euler block.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package qte_pkg;

  localparam int IN_W      = 16;  // Q1.15 quaternion component
  localparam int PROD_W    = 32;  // exact Q2.30 product
  localparam int VEC_W     = 34;  // atan2 operands before scaling
  localparam int S_W       = 32;  // clamped arcsine argument
  localparam int MAG_W     = 31;  // |s| <= 2^30
  localparam int RAD_W     = 61;  // radicand 2^60 - s^2
  localparam int REM_W     = 62;  // square root remainder
  localparam int ROOT_W    = 31;  // square root result, <= 2^30
  localparam int CW        = 44;  // CORDIC vector width
  localparam int ZW        = 24;  // angle accumulator, radians * 2^20
  localparam int SH_W      = 6;   // scale shift count
  localparam int OUT_W     = 16;  // Q3.13 angle
  localparam int TABLE_LEN = 24;
  localparam int NORM_BIT  = 40;  // scale until one component reaches 2^40

  typedef logic signed [ZW-1:0] angle_t;

  localparam angle_t PI_FIX = 24'sd3294199;
  localparam logic signed [VEC_W-1:0] ONE_VEC = 34'sh040000000;

  // atan(2^-i) * 2^20, rounded
  localparam angle_t ROT_ANGLE [TABLE_LEN] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451, 24'sd32757,
    24'sd16383, 24'sd8192, 24'sd4096, 24'sd2048, 24'sd1024, 24'sd512,
    24'sd256, 24'sd128, 24'sd64, 24'sd32, 24'sd16, 24'sd8,
    24'sd4, 24'sd2, 24'sd1, 24'sd0, 24'sd0, 24'sd0
  };

  // one atan2 operand pair
  typedef struct packed {
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] x;
  } vec_t;

  // operands that ride alongside the square root pipeline
  typedef struct packed {
    vec_t ax;
    vec_t az;
  } side_t;

endpackage

>>> rtl/core/qte_in_if.sv
// Valid/ready channel carrying one quaternion request.
// Uses qte_pkg for the component width.
interface qte_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [qte_pkg::IN_W-1:0]  quat_w;
  logic signed [qte_pkg::IN_W-1:0]  quat_x;
  logic signed [qte_pkg::IN_W-1:0]  quat_y;
  logic signed [qte_pkg::IN_W-1:0]  quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> rtl/core/qte_out_if.sv
// Valid/ready channel carrying one set of Euler angles.
// Uses qte_pkg for the angle width.
interface qte_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qte_pkg::OUT_W-1:0]  angle_x;
  logic signed [qte_pkg::OUT_W-1:0]  angle_y;
  logic signed [qte_pkg::OUT_W-1:0]  angle_z;

  modport source (output valid, angle_x, angle_y, angle_z, input ready);
  modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface

>>> rtl/core/qte_front.sv
// Front end: component products, then the atan2 operands and clamped arcsine argument.
// Two register stages. Depends on qte_pkg.
module qte_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qte_pkg::IN_W-1:0]   quat_w,
  input  logic signed [qte_pkg::IN_W-1:0]   quat_x,
  input  logic signed [qte_pkg::IN_W-1:0]   quat_y,
  input  logic signed [qte_pkg::IN_W-1:0]   quat_z,
  output logic                              out_valid,
  output qte_pkg::vec_t                     ax,
  output qte_pkg::vec_t                     az,
  output logic signed [qte_pkg::S_W-1:0]    s
);

  logic signed [qte_pkg::PROD_W-1:0] ww, xx, yy, zz, yz, xw, xy, zw, xz, yw;
  logic                              v1;
  logic signed [qte_pkg::VEC_W-1:0]  s_raw;
  qte_pkg::vec_t                     ax_next, az_next;
  logic signed [qte_pkg::S_W-1:0]    s_next;

  // stage 1: ten exact products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ww <= quat_w * quat_w;
      xx <= quat_x * quat_x;
      yy <= quat_y * quat_y;
      zz <= quat_z * quat_z;
      yz <= quat_y * quat_z;
      xw <= quat_x * quat_w;
      xy <= quat_x * quat_y;
      zw <= quat_z * quat_w;
      xz <= quat_x * quat_z;
      yw <= quat_y * quat_w;
    end
  end

  // stage 2: sums and the arcsine clamp
  always_comb begin
    ax_next.y = (qte_pkg::VEC_W'(yz) + qte_pkg::VEC_W'(xw)) <<< 1;
    ax_next.x = qte_pkg::VEC_W'(ww) - qte_pkg::VEC_W'(xx)
              - qte_pkg::VEC_W'(yy) + qte_pkg::VEC_W'(zz);
    az_next.y = (qte_pkg::VEC_W'(xy) + qte_pkg::VEC_W'(zw)) <<< 1;
    az_next.x = qte_pkg::VEC_W'(ww) + qte_pkg::VEC_W'(xx)
              - qte_pkg::VEC_W'(yy) - qte_pkg::VEC_W'(zz);
    s_raw     = (qte_pkg::VEC_W'(yw) - qte_pkg::VEC_W'(xz)) <<< 1;
    if (s_raw > qte_pkg::ONE_VEC) begin
      s_next = qte_pkg::S_W'(qte_pkg::ONE_VEC);
    end else if (s_raw < -qte_pkg::ONE_VEC) begin
      s_next = qte_pkg::S_W'(-qte_pkg::ONE_VEC);
    end else begin
      s_next = qte_pkg::S_W'(s_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= ax_next;
      az <= az_next;
      s  <= s_next;
    end
  end

endmodule

>>> rtl/core/qte_cos.sv
// Cosine term for the arcsine: c = floor(sqrt(2^60 - s^2)), one root bit per stage.
// Squares s from partial products of |s| split at bit 16 first. Depends on qte_pkg.
module qte_cos (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [qte_pkg::S_W-1:0]    s_in,
  input  qte_pkg::side_t                    side_in,
  output logic                              out_valid,
  output logic [qte_pkg::ROOT_W-1:0]        c,
  output logic signed [qte_pkg::S_W-1:0]    s_out,
  output qte_pkg::side_t                    side_out
);

  localparam int N = qte_pkg::ROOT_W;

  logic [qte_pkg::MAG_W-1:0]       s_mag;
  logic [29:0]                     aa;
  logic [30:0]                     ab;
  logic [31:0]                     bb;
  logic                            vm;
  logic signed [qte_pkg::S_W-1:0]  s_m;
  qte_pkg::side_t                  side_m;
  logic [qte_pkg::RAD_W-1:0]       sq;

  logic [qte_pkg::REM_W-1:0]       rem  [0:N];
  logic [qte_pkg::ROOT_W-1:0]      root [0:N];
  logic signed [qte_pkg::S_W-1:0]  s_r  [0:N];
  qte_pkg::side_t                  side_r [0:N];
  logic [N:0]                      vr;

  // partial products of |s| split at bit 16
  assign s_mag = (s_in < 0) ? qte_pkg::MAG_W'(-s_in) : qte_pkg::MAG_W'(s_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      aa     <= s_mag[30:16] * s_mag[30:16];
      ab     <= s_mag[30:16] * s_mag[15:0];
      bb     <= s_mag[15:0] * s_mag[15:0];
      s_m    <= s_in;
      side_m <= side_in;
    end
  end

  // s^2 from the partial products, for the radicand 2^60 - s^2
  assign sq = (qte_pkg::RAD_W'(aa) << 32) + (qte_pkg::RAD_W'(ab) << 17)
            + qte_pkg::RAD_W'(bb);

  always_ff @(posedge clk) begin
    if (rst) begin
      vr[0] <= 1'b0;
    end else if (en) begin
      vr[0] <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= qte_pkg::REM_W'((qte_pkg::RAD_W'(1) << 60) - sq);
      root[0]   <= '0;
      s_r[0]    <= s_m;
      side_r[0] <= side_m;
    end
  end

  // one root bit per stage, most significant first
  for (genvar k = 0; k < N; k++) begin : g_root
    localparam int B = N - 1 - k;
    logic [qte_pkg::REM_W-1:0] cand;

    assign cand = ((qte_pkg::REM_W'(root[k]) << 1) + (qte_pkg::REM_W'(1) << B)) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        vr[k+1] <= 1'b0;
      end else if (en) begin
        vr[k+1] <= vr[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= cand) begin
          rem[k+1]  <= rem[k] - cand;
          root[k+1] <= root[k] | (qte_pkg::ROOT_W'(1) << B);
        end else begin
          rem[k+1]  <= rem[k];
          root[k+1] <= root[k];
        end
        s_r[k+1]    <= s_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vr[N];
  assign c         = root[N];
  assign s_out     = s_r[N];
  assign side_out  = side_r[N];

endmodule

>>> rtl/core/qte_atan2.sv
// Pipelined four-quadrant arctangent: quadrant fold, scale search, scale shift,
// one CORDIC micro-rotation per stage, then rounding to Q3.13. Depends on qte_pkg.
module qte_atan2 #(
  parameter int STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  qte_pkg::vec_t                     vec,
  output logic                              out_valid,
  output logic signed [qte_pkg::OUT_W-1:0]  angle
);

  localparam int NSTEP = (STEPS > qte_pkg::TABLE_LEN) ? qte_pkg::TABLE_LEN : STEPS;

  logic signed [qte_pkg::VEC_W-1:0] xq, yq, xn, yn, my;
  qte_pkg::angle_t                  zq, zn;
  logic                             vq, vn;
  logic [qte_pkg::VEC_W-1:0]        m;
  logic [qte_pkg::SH_W-1:0]         msb, sh_next, shn;

  logic signed [qte_pkg::CW-1:0]    xc [0:NSTEP];
  logic signed [qte_pkg::CW-1:0]    yc [0:NSTEP];
  qte_pkg::angle_t                  zc [0:NSTEP];
  logic [NSTEP:0]                   vc;

  logic signed [qte_pkg::ZW:0]      rsum, rq;
  logic signed [qte_pkg::OUT_W-1:0] angle_next;

  // quadrant fold: left half-plane turns by pi
  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= 1'b0;
    end else if (en) begin
      vq <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (vec.x < 0) begin
        xq <= -vec.x;
        yq <= -vec.y;
        zq <= (vec.y >= 0) ? qte_pkg::PI_FIX : -qte_pkg::PI_FIX;
      end else begin
        xq <= vec.x;
        yq <= vec.y;
        zq <= '0;
      end
    end
  end

  // scale search: shift so the larger magnitude lands at bit 40
  always_comb begin
    my  = (yq < 0) ? -yq : yq;
    m   = xq | my;
    msb = '0;
    for (int i = 0; i < qte_pkg::VEC_W; i++) begin
      if (m[i]) begin
        msb = qte_pkg::SH_W'(i);
      end
    end
    sh_next = (m == '0) ? '0 : qte_pkg::SH_W'(qte_pkg::NORM_BIT) - msb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= vq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn  <= xq;
      yn  <= yq;
      zn  <= zq;
      shn <= sh_next;
    end
  end

  // scale shift
  always_ff @(posedge clk) begin
    if (rst) begin
      vc[0] <= 1'b0;
    end else if (en) begin
      vc[0] <= vn;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xc[0] <= qte_pkg::CW'(xn) <<< shn;
      yc[0] <= qte_pkg::CW'(yn) <<< shn;
      zc[0] <= zn;
    end
  end

  // micro-rotations; a vector already on the axis passes unchanged
  for (genvar k = 0; k < NSTEP; k++) begin : g_rot
    always_ff @(posedge clk) begin
      if (rst) begin
        vc[k+1] <= 1'b0;
      end else if (en) begin
        vc[k+1] <= vc[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (yc[k] == 0) begin
          xc[k+1] <= xc[k];
          yc[k+1] <= yc[k];
          zc[k+1] <= zc[k];
        end else if (yc[k] > 0) begin
          xc[k+1] <= xc[k] + (yc[k] >>> k);
          yc[k+1] <= yc[k] - (xc[k] >>> k);
          zc[k+1] <= zc[k] + qte_pkg::ROT_ANGLE[k];
        end else begin
          xc[k+1] <= xc[k] - (yc[k] >>> k);
          yc[k+1] <= yc[k] + (xc[k] >>> k);
          zc[k+1] <= zc[k] - qte_pkg::ROT_ANGLE[k];
        end
      end
    end
  end

  // round half up to 2^-13 and saturate
  always_comb begin
    rsum = (qte_pkg::ZW+1)'(zc[NSTEP]) + (qte_pkg::ZW+1)'(64);
    rq   = rsum >>> 7;
    if (rq > (qte_pkg::ZW+1)'(32767)) begin
      angle_next = 16'sh7fff;
    end else if (rq < -(qte_pkg::ZW+1)'(32768)) begin
      angle_next = 16'sh8000;
    end else begin
      angle_next = qte_pkg::OUT_W'(rq);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vc[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= angle_next;
    end
  end

endmodule

>>> rtl/core/quaternion_to_euler_xyz_top.sv
// Top level of the quaternion to XYZ Euler angle converter.
// Depends on qte_pkg, qte_in_if, qte_out_if, qte_front, qte_cos and qte_atan2.
//
// Usage:
//   quat_in carries one quaternion (w, x, y, z, signed Q1.15) per request;
//   angle_out carries angle_x, angle_y, angle_z (signed Q3.13 radians).
//   Both channels use valid/ready; a request moves when both are high.
// Pipeline order: products and sums, then the squaring and the bit-per-stage
//   square root of the arcsine's cosine term, then the atan2 lanes with one
//   micro-rotation per step (CORDIC_STEPS above 24 counts as 24).
// Throughput: one request per cycle unless stalled; the three atan2 lanes and
//   square root are fully pipelined, one stage per root bit and micro-rotation.
// Stall: the last stage is the output register. While it holds a request
//   that the receiver has not taken, the whole pipeline holds and
//   quat_in.ready is low; nothing is dropped or repeated. An empty output
//   register or a taken result lets every stage advance.
// Reset: clears all stage valid bits; the block is ready on the next cycle.
module quaternion_to_euler_xyz_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  qte_in_if.sink      quat_in,
  qte_out_if.source   angle_out
);

  logic                              en;
  logic                              front_valid, cos_valid;
  qte_pkg::vec_t                     ax, az, ay_vec;
  logic signed [qte_pkg::S_W-1:0]    s, s_c;
  logic [qte_pkg::ROOT_W-1:0]        c;
  qte_pkg::side_t                    side_in, side_c;
  logic signed [qte_pkg::OUT_W-1:0]  ang_x, ang_y, ang_z;
  logic                              lane_valid_x, lane_valid_y, lane_valid_z;

  // global advance: output register empty or being taken
  assign en            = !angle_out.valid || angle_out.ready;
  assign quat_in.ready = en;

  qte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quat_in.valid),
    .quat_w    (quat_in.quat_w),
    .quat_x    (quat_in.quat_x),
    .quat_y    (quat_in.quat_y),
    .quat_z    (quat_in.quat_z),
    .out_valid (front_valid),
    .ax        (ax),
    .az        (az),
    .s         (s)
  );

  assign side_in.ax = ax;
  assign side_in.az = az;

  qte_cos u_cos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .s_in      (s),
    .side_in   (side_in),
    .out_valid (cos_valid),
    .c         (c),
    .s_out     (s_c),
    .side_out  (side_c)
  );

  // arcsine as atan2(s, sqrt(1 - s^2))
  assign ay_vec.y = qte_pkg::VEC_W'(s_c);
  assign ay_vec.x = qte_pkg::VEC_W'(c);

  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cos_valid),
    .vec       (side_c.ax),
    .out_valid (lane_valid_x),
    .angle     (ang_x)
  );

  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cos_valid),
    .vec       (ay_vec),
    .out_valid (lane_valid_y),
    .angle     (ang_y)
  );

  qte_atan2 #(.STEPS(CORDIC_STEPS)) u_lane_z (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cos_valid),
    .vec       (side_c.az),
    .out_valid (lane_valid_z),
    .angle     (ang_z)
  );

  // the lanes run in lockstep, so their valid bits agree
  assign angle_out.valid   = lane_valid_x & lane_valid_y & lane_valid_z;
  assign angle_out.angle_x = ang_x;
  assign angle_out.angle_y = ang_y;
  assign angle_out.angle_z = ang_z;

endmodule

>>> rtl/core/qte_checker.sv
// Port-level checks for quaternion_to_euler_xyz_top, attached by bind.
// Depends on qte_pkg for widths.
module qte_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [qte_pkg::OUT_W-1:0]  angle_x,
  input logic signed [qte_pkg::OUT_W-1:0]  angle_y,
  input logic signed [qte_pkg::OUT_W-1:0]  angle_z
);

  // a pending result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a pending result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(angle_x) && $stable(angle_y) && $stable(angle_z))
    else $error("result changed while stalled");

  // input side moves exactly when the output register can advance
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // arcsine result stays within about pi/2
  a_y_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (angle_y <= 16'sd12870) && (angle_y >= -16'sd12870))
    else $error("angle_y outside +-pi/2");

  // nothing offered right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result offered after reset");

endmodule

bind quaternion_to_euler_xyz_top qte_checker u_qte_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (quat_in.ready),
  .out_valid (angle_out.valid),
  .out_ready (angle_out.ready),
  .angle_x   (angle_out.angle_x),
  .angle_y   (angle_out.angle_y),
  .angle_z   (angle_out.angle_z)
);
